// ===== rtl/core/clpp_pkg.sv =====
// Shared package for the CAN log page packer.
// Holds default sizes, record layout constants, FSM state and control structs.
// No dependencies.
package clpp_pkg;

    localparam int DEF_PAGE_BYTES = 512;
    localparam int DEF_PAGE_SLOTS = 4;

    localparam int LANE_BYTES = 8;
    localparam int SIG_BYTES  = 4;
    localparam int HDR_BYTES  = 9;

    localparam logic [3:0] MAX_DATA = 4'd8;

    localparam logic [7:0]  PAD_BYTE = 8'hFF;
    localparam logic [63:0] PAD_WORD = {LANE_BYTES{PAD_BYTE}};
    localparam logic [7:0]  SIG_L    = 8'h4C;
    localparam logic [7:0]  SIG_O    = 8'h4F;
    localparam logic [7:0]  SIG_G    = 8'h47;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_BUILD,
        ST_WRITE,
        ST_SEND
    } clpp_state_t;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] byte_en;
    } ram_ctl_t;

    typedef struct packed {
        logic load;
        logic advance;
    } shift_ctl_t;

endpackage

// ===== rtl/core/clpp_page_ram.sv =====
// Page store: single-port synchronous RAM, 64-bit words, byte write enables.
// Read data registered. Depends on clpp_pkg.
module clpp_page_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clpp_pkg::ram_ctl_t   ctl,
    input  logic [ADDR_W-1:0]    addr,
    input  logic [63:0]          wdata,
    output logic [63:0]          rdata
);
    import clpp_pkg::*;

    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            for (int b = 0; b < LANE_BYTES; b++)
            begin
                if (ctl.byte_en[b])
                begin
                    mem[addr][b*8 +: 8] <= wdata[b*8 +: 8];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.wr_en && ctl.rd_en))
        else $error("page ram read and write in the same cycle");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr_en || ctl.rd_en) |-> ({1'b0, addr} < (ADDR_W + 1)'(DEPTH)))
        else $error("page ram address out of range");

endmodule

// ===== rtl/core/clpp_rec_shifter.sv =====
// Record shifter: assembles signature and record bytes, aligns them to the
// byte offset in a word, then hands out one word and byte mask per step.
// Depends on clpp_pkg.
module clpp_rec_shifter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clpp_pkg::shift_ctl_t ctl,
    input  logic                 sig,
    input  logic [7:0]           page_count,
    input  logic [28:0]          msg_id,
    input  logic [31:0]          stamp,
    input  logic [3:0]           len,
    input  logic [63:0]          data,
    input  logic [2:0]           offset,
    output logic [63:0]          word,
    output logic [7:0]           byte_en,
    output logic                 pending
);
    import clpp_pkg::*;

    logic [255:0] sh_data_reg;
    logic [31:0]  sh_mask_reg;
    logic [135:0] body;
    logic [16:0]  body_mask;
    logic [255:0] rec;
    logic [31:0]  rec_mask;

    always_comb
    begin
        body      = {data, 4'b0000, len, stamp, 3'b000, msg_id};
        body_mask = ~({17{1'b1}} << (5'(HDR_BYTES) + 5'(len)));
        if (sig)
        begin
            rec      = 256'({body, page_count, SIG_G, SIG_O, SIG_L});
            rec_mask = 32'({body_mask, 4'hF});
        end
        else
        begin
            rec      = 256'(body);
            rec_mask = 32'(body_mask);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            sh_data_reg <= rec << {offset, 3'b000};
        end
        else if (ctl.advance)
        begin
            sh_data_reg <= sh_data_reg >> 64;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_mask_reg <= '0;
        end
        else if (ctl.load)
        begin
            sh_mask_reg <= rec_mask << offset;
        end
        else if (ctl.advance)
        begin
            sh_mask_reg <= sh_mask_reg >> LANE_BYTES;
        end
    end

    assign word    = sh_data_reg[63:0];
    assign byte_en = sh_mask_reg[7:0];
    assign pending = |sh_mask_reg;

endmodule

// ===== rtl/core/can_log_page_packer_unit.sv =====
// Top level of the CAN log page packer: control FSM, ring pointers and flags.
// Instantiates clpp_page_ram and clpp_rec_shifter; depends on clpp_pkg.
//
//   channel  dir  handshake               payload
//   cmd      in   cmd_valid / cmd_stall    operation, message_id, timestamp,
//                                          data_length, payload
//   word     out  word_valid / word_stall  page_word, last_word
//
// Append: the record is loaded into the shifter, then written with one page
// RAM word write per cycle (two or three words per record); closing a page
// first writes a pad word to each remaining word of the page.
// Flush: one word per cycle from the single RAM port while word is not
// stalled; an empty flush goes straight back to idle.
// Reset clears pointers, flags and counter; the page store is not cleared.
// A stall on word holds the current word; cmd is stalled until the item is done.
module can_log_page_packer_unit #(
    parameter int PAGE_BYTES = clpp_pkg::DEF_PAGE_BYTES,
    parameter int PAGE_SLOTS = clpp_pkg::DEF_PAGE_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic        operation,
    input  logic [28:0] message_id,
    input  logic [31:0] timestamp,
    input  logic [3:0]  data_length,
    input  logic [63:0] payload,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [63:0] page_word,
    output logic        last_word
);
    import clpp_pkg::*;

    localparam int PAGE_WORDS = (PAGE_BYTES + 7) / 8;
    localparam int DEPTH      = PAGE_SLOTS * PAGE_WORDS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int SLOT_W     = $clog2(PAGE_SLOTS);
    localparam int POS_W      = $clog2(PAGE_BYTES + 1);
    localparam int WORD_W     = $clog2(PAGE_WORDS);
    localparam int WIDX_W     = $clog2(PAGE_WORDS + 1);
    localparam int LAST_BYTES = PAGE_BYTES - 8 * (PAGE_WORDS - 1);
    localparam logic [63:0] LAST_MASK = {64{1'b1}} >> (64 - 8 * LAST_BYTES);

    clpp_state_t              state_reg, state_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [PAGE_SLOTS-1:0]    ready_reg, ready_next;
    logic [SLOT_W-1:0]        fill_reg, fill_next;
    logic [SLOT_W-1:0]        drain_reg, drain_next;
    logic [7:0]               count_reg, count_next;
    logic [WIDX_W-1:0]        pad_word_reg, pad_word_next;
    logic                     pad_first_reg, pad_first_next;
    logic [WIDX_W-1:0]        wr_word_reg, wr_word_next;
    logic [WORD_W-1:0]        rd_word_reg, rd_word_next;

    logic [28:0]              id_reg;
    logic [31:0]              ts_reg;
    logic [3:0]               len_reg;
    logic [63:0]              data_reg;

    logic                     cmd_take;
    logic                     word_take;
    logic [3:0]               len_clamp;
    logic [POS_W-1:0]         room;
    logic [POS_W-1:0]         need;
    logic                     fit;
    logic                     build_sig;
    logic [2:0]               build_off;
    logic                     is_last;

    ram_ctl_t                 ram_ctl;
    logic [SLOT_W-1:0]        ram_slot;
    logic [WORD_W-1:0]        ram_word;
    logic [ADDR_W-1:0]        ram_addr;
    logic [63:0]              ram_wdata;
    logic [63:0]              ram_rdata;

    shift_ctl_t               shift_ctl;
    logic [63:0]              sh_word;
    logic [7:0]               sh_be;
    logic                     sh_pending;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(PAGE_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    assign cmd_take  = cmd_valid && !cmd_stall;
    assign word_take = word_valid && !word_stall;
    assign len_clamp = (data_length > MAX_DATA) ? MAX_DATA : data_length;
    assign room      = POS_W'(PAGE_BYTES) - pos_reg;
    assign need      = POS_W'(HDR_BYTES) + POS_W'(len_clamp);
    assign fit       = (pos_reg <= POS_W'(PAGE_BYTES)) && (room >= need);
    assign build_sig = pos_reg < POS_W'(SIG_BYTES);
    assign build_off = build_sig ? 3'd0 : pos_reg[2:0];
    assign is_last   = rd_word_reg == WORD_W'(PAGE_WORDS - 1);
    assign ram_addr  = ADDR_W'(ram_slot) * ADDR_W'(PAGE_WORDS) + ADDR_W'(ram_word);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    if (operation == OP_FLUSH)
                    begin
                        state_next = ready_reg[drain_reg] ? ST_SEND : ST_IDLE;
                    end
                    else
                    begin
                        state_next = fit ? ST_BUILD : ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_word_reg == WIDX_W'(PAGE_WORDS))
                begin
                    state_next = ST_BUILD;
                end
            end
            ST_BUILD:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!sh_pending)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEND:
            begin
                if (word_take && is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pos_next       = pos_reg;
        ready_next     = ready_reg;
        fill_next      = fill_reg;
        drain_next     = drain_reg;
        count_next     = count_reg;
        pad_word_next  = pad_word_reg;
        pad_first_next = pad_first_reg;
        wr_word_next   = wr_word_reg;
        rd_word_next   = rd_word_reg;
        ram_ctl        = '0;
        ram_slot       = fill_reg;
        ram_word       = '0;
        ram_wdata      = PAD_WORD;
        shift_ctl      = '0;
        cmd_stall      = state_reg != ST_IDLE;
        word_valid     = state_reg == ST_SEND;
        last_word      = is_last;
        page_word      = is_last ? (ram_rdata & LAST_MASK) : ram_rdata;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    if (operation == OP_FLUSH)
                    begin
                        if (ready_reg[drain_reg])
                        begin
                            ram_ctl.rd_en = 1'b1;
                            ram_slot      = drain_reg;
                            ram_word      = '0;
                            rd_word_next  = '0;
                        end
                    end
                    else
                    begin
                        pad_word_next  = WIDX_W'(pos_reg >> 3);
                        pad_first_next = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_word_reg == WIDX_W'(PAGE_WORDS))
                begin
                    ready_next = ready_reg | (PAGE_SLOTS'(1) << fill_reg);
                    fill_next  = next_slot(fill_reg);
                    count_next = count_reg + 8'd1;
                    pos_next   = '0;
                end
                else
                begin
                    ram_ctl.wr_en   = 1'b1;
                    ram_ctl.byte_en = pad_first_reg ? (PAD_BYTE << pos_reg[2:0]) : PAD_BYTE;
                    ram_word        = pad_word_reg[WORD_W-1:0];
                    pad_word_next   = pad_word_reg + 1'b1;
                    pad_first_next  = 1'b0;
                end
            end
            ST_BUILD:
            begin
                shift_ctl.load = 1'b1;
                pos_next       = (build_sig ? POS_W'(SIG_BYTES) : pos_reg)
                                 + POS_W'(HDR_BYTES) + POS_W'(len_reg);
                wr_word_next   = build_sig ? '0 : WIDX_W'(pos_reg >> 3);
            end
            ST_WRITE:
            begin
                if (sh_pending)
                begin
                    ram_ctl.wr_en     = 1'b1;
                    ram_ctl.byte_en   = sh_be;
                    ram_wdata         = sh_word;
                    ram_word          = wr_word_reg[WORD_W-1:0];
                    shift_ctl.advance = 1'b1;
                    wr_word_next      = wr_word_reg + 1'b1;
                end
            end
            ST_SEND:
            begin
                if (word_take)
                begin
                    if (is_last)
                    begin
                        ready_next = ready_reg & ~(PAGE_SLOTS'(1) << drain_reg);
                        drain_next = next_slot(drain_reg);
                    end
                    else
                    begin
                        ram_ctl.rd_en = 1'b1;
                        ram_slot      = drain_reg;
                        ram_word      = rd_word_reg + 1'b1;
                        rd_word_next  = rd_word_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                ram_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            ready_reg     <= '0;
            fill_reg      <= '0;
            drain_reg     <= '0;
            count_reg     <= '0;
            pad_word_reg  <= '0;
            pad_first_reg <= 1'b0;
            wr_word_reg   <= '0;
            rd_word_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            ready_reg     <= ready_next;
            fill_reg      <= fill_next;
            drain_reg     <= drain_next;
            count_reg     <= count_next;
            pad_word_reg  <= pad_word_next;
            pad_first_reg <= pad_first_next;
            wr_word_reg   <= wr_word_next;
            rd_word_reg   <= rd_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take && (operation == OP_APPEND))
        begin
            id_reg   <= message_id;
            ts_reg   <= timestamp;
            len_reg  <= len_clamp;
            data_reg <= payload;
        end
    end

    clpp_page_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    clpp_rec_shifter u_shifter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (shift_ctl),
        .sig        (build_sig),
        .page_count (count_reg),
        .msg_id     (id_reg),
        .stamp      (ts_reg),
        .len        (len_reg),
        .data       (data_reg),
        .offset     (build_off),
        .word       (sh_word),
        .byte_en    (sh_be),
        .pending    (sh_pending)
    );

    a_send_ready: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> ready_reg[drain_reg])
        else $error("streaming a page that is not ready");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (word_take && last_word) |=> !word_valid)
        else $error("word stream continues past the last word");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(PAGE_BYTES))
        else $error("write position beyond page");

endmodule

// ===== test/can_log_page_packer_unit_tb.sv =====
// Testbench for can_log_page_packer_unit: drives append and flush items and
// checks each flushed page word against a byte-level page ring model.
// Depends on clpp_pkg and the can_log_page_packer_unit RTL.
module can_log_page_packer_unit_tb;
    import clpp_pkg::*;

    localparam int PAGE_BYTES     = DEF_PAGE_BYTES;
    localparam int PAGE_SLOTS     = DEF_PAGE_SLOTS;
    localparam int PAGE_WORDS     = (PAGE_BYTES + 7) / 8;
    localparam int IDLE_PCT       = 26;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_TAIL     = 2 * PAGE_WORDS + 20;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [63:0] word;
        logic        last;
    } page_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic        operation = OP_APPEND;
    logic [28:0] message_id = '0;
    logic [31:0] timestamp = '0;
    logic [3:0]  data_length = '0;
    logic [63:0] payload = '0;
    logic        word_valid;
    logic        word_stall = 1'b0;
    logic [63:0] page_word;
    logic        last_word;

    logic [7:0]            page_mem [PAGE_SLOTS][PAGE_BYTES];
    int unsigned           wr_pos = 0;
    logic [PAGE_SLOTS-1:0] ready_mask = '0;
    int unsigned           fill_idx = 0;
    int unsigned           drain_idx = 0;
    logic [7:0]            page_num = '0;
    page_word_t            page_words_due[$];

    int  items_sent = 0;
    int  words_checked = 0;
    int  pages_closed = 0;
    int  pages_flushed = 0;
    int  ring_laps = 0;
    int  empty_flushes = 0;
    int  errors = 0;
    int  idle_cycles = 0;
    bit  steady = 1'b0;
    bit  hold_on = 1'b0;
    event hold_go;

    can_log_page_packer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .operation   (operation),
        .message_id  (message_id),
        .timestamp   (timestamp),
        .data_length (data_length),
        .payload     (payload),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .page_word   (page_word),
        .last_word   (last_word)
    );

    always #1 clk = ~clk;

    function automatic void store_byte(int unsigned addr, logic [7:0] value);
        if (addr < PAGE_BYTES)
            page_mem[fill_idx][addr] = value;
    endfunction

    function automatic void pack_record(logic [28:0] id, logic [31:0] stamp,
                                        logic [3:0] len_field, logic [63:0] data);
        int unsigned pos;
        int unsigned len;
        logic [31:0] id_bytes;
        pos = wr_pos;
        len = (len_field > MAX_DATA) ? MAX_DATA : len_field;
        id_bytes = {3'b000, id};
        if (pos > PAGE_BYTES || PAGE_BYTES - pos < HDR_BYTES + len) begin
            while (pos < PAGE_BYTES) begin
                store_byte(pos, PAD_BYTE);
                pos++;
            end
            ready_mask[fill_idx] = 1'b1;
            fill_idx = (fill_idx + 1) % PAGE_SLOTS;
            page_num = page_num + 8'd1;
            pages_closed++;
            if (ready_mask[fill_idx])
                ring_laps++;
            pos = 0;
        end
        if (pos < SIG_BYTES) begin
            store_byte(0, SIG_L);
            store_byte(1, SIG_O);
            store_byte(2, SIG_G);
            store_byte(3, page_num);
            pos = SIG_BYTES;
        end
        for (int i = 0; i < 4; i++) begin
            store_byte(pos + i, id_bytes[8*i +: 8]);
            store_byte(pos + 4 + i, stamp[8*i +: 8]);
        end
        store_byte(pos + 8, 8'(len));
        for (int i = 0; i < len; i++)
            store_byte(pos + HDR_BYTES + i, data[8*i +: 8]);
        wr_pos = (pos + HDR_BYTES + len) & 32'h3FF;
    endfunction

    function automatic void drain_page();
        page_word_t  due;
        int unsigned addr;
        if (!ready_mask[drain_idx]) begin
            empty_flushes++;
            return;
        end
        for (int w = 0; w < PAGE_WORDS; w++) begin
            due.word = '0;
            for (int b = 0; b < LANE_BYTES; b++) begin
                addr = w * LANE_BYTES + b;
                if (addr < PAGE_BYTES)
                    due.word[8*b +: 8] = page_mem[drain_idx][addr];
            end
            due.last = (w == PAGE_WORDS - 1);
            page_words_due.push_back(due);
        end
        ready_mask[drain_idx] = 1'b0;
        drain_idx = (drain_idx + 1) % PAGE_SLOTS;
        pages_flushed++;
    endfunction

    task automatic issue_cmd(input logic op, input logic [28:0] id, input logic [31:0] stamp,
                             input logic [3:0] len_field, input logic [63:0] data);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid   <= 1'b1;
        operation   <= op;
        message_id  <= id;
        timestamp   <= stamp;
        data_length <= len_field;
        payload     <= data;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (op == OP_FLUSH)
            drain_page();
        else
            pack_record(id, stamp, len_field, data);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic issue_random_record(input int long_pct);
        logic [3:0] len_field;
        if ($urandom_range(0, 99) < long_pct)
            len_field = 4'($urandom_range(8, 15));
        else
            len_field = 4'($urandom_range(0, 15));
        issue_cmd(OP_APPEND, 29'($urandom), $urandom, len_field, {$urandom, $urandom});
    endtask

    task automatic issue_flush();
        issue_cmd(OP_FLUSH, 29'($urandom), $urandom, 4'($urandom), {$urandom, $urandom});
    endtask

    task automatic wait_drain();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (page_words_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_steady(input bit on);
        cmd_valid <= 1'b0;
        @(posedge clk);
        steady = on;
        @(negedge clk);
    endtask

    task automatic test_edge_records();
        issue_cmd(OP_FLUSH, '0, '0, '0, '0);
        issue_cmd(OP_APPEND, '0, '0, 4'd0, '0);
        issue_cmd(OP_APPEND, '1, '1, 4'd8, '1);
        issue_cmd(OP_APPEND, 29'h0AAAAAAA, 32'h55555555, 4'd15, 64'hA5A5_5A5A_0F0F_F0F0);
        issue_cmd(OP_APPEND, 29'h15555555, 32'hAAAAAAAA, 4'd9, 64'h5A5A_A5A5_F0F0_0F0F);
        issue_cmd(OP_APPEND, 29'h10000000, 32'h80000000, 4'd12, 64'h8000_0000_0000_0001);
        issue_cmd(OP_APPEND, 29'($urandom), $urandom, 4'd1, {$urandom, $urandom});
        issue_cmd(OP_APPEND, 29'($urandom), $urandom, 4'd4, {$urandom, $urandom});
        issue_cmd(OP_APPEND, 29'($urandom), $urandom, 4'd7, {$urandom, $urandom});
        issue_cmd(OP_FLUSH, '1, '1, '1, '1);
        wait_drain();
    endtask

    task automatic test_page_turnover();
        int closed_at_start;
        closed_at_start = pages_closed;
        while (pages_closed == closed_at_start)
            issue_random_record(30);
        issue_flush();
        wait_drain();
        issue_flush();
        wait_drain();
    endtask

    task automatic test_ring_lap();
        set_steady(1'b1);
        repeat (40)
            issue_random_record(90);
        set_steady(1'b0);
        while (ring_laps == 0)
            issue_random_record(90);
        repeat (3)
            issue_random_record(50);
        -> hold_go;
        repeat (PAGE_SLOTS + 1)
            issue_flush();
        wait_drain();
    endtask

    task automatic test_mixed_noise();
        repeat (16) begin
            if ($urandom_range(0, 99) < 25)
                issue_flush();
            else
                issue_random_record(20);
        end
    endtask

    always @(negedge clk)
        word_stall <= hold_on || (!steady && $urandom_range(0, 99) < IDLE_PCT);

    initial begin
        forever begin
            @(hold_go);
            @(posedge clk);
            hold_on = 1'b1;
            repeat (HOLD_CYCLES)
                @(posedge clk);
            hold_on = 1'b0;
        end
    end

    always @(posedge clk) begin
        page_word_t due;
        if (rst_n && word_valid && !word_stall) begin
            if (page_words_due.size() == 0) begin
                $error("page_word: expected none, got %h", page_word);
                errors++;
            end
            else begin
                due = page_words_due.pop_front();
                if (page_word !== due.word) begin
                    $error("page_word: expected %h, got %h", due.word, page_word);
                    errors++;
                end
                if (last_word !== due.last) begin
                    $error("last_word: expected %b, got %b", due.last, last_word);
                    errors++;
                end
                words_checked++;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (word_valid && !word_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[can_log_page_packer_unit] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_edge_records();
        test_page_turnover();
        test_ring_lap();
        test_mixed_noise();
        wait_drain();
        repeat (DRAIN_TAIL)
            @(posedge clk);
        $display("run: %0d items, %0d pages closed, %0d ring laps, %0d pages flushed",
                 items_sent, pages_closed, ring_laps, pages_flushed);
        $display("run: %0d page words checked, %0d flushes with no page ready, %0d errors",
                 words_checked, empty_flushes, errors);
        if (errors == 0)
            $display("[can_log_page_packer_unit] OK");
        else
            $display("[can_log_page_packer_unit] ERROR");
        $finish;
    end
endmodule
